[rtl/sprd_pkg.sv]
// Package of the serial packet deframer: sizes, codes and the result word.
`default_nettype none
package sprd_pkg;

    localparam int STORE_BYTES    = 512;
    localparam int ADDR_W         = $clog2(STORE_BYTES);
    localparam int CNT_W          = $clog2(STORE_BYTES + 1);
    localparam int PARSE_PER_STEP = 32;
    localparam int K_W            = $clog2(PARSE_PER_STEP + 1);
    localparam int HEADER_BYTES   = 12;
    localparam int HDR_REGS       = 16;
    localparam logic [7:0] MAGIC_BYTE   = 8'h41;
    localparam logic [7:0] VERSION_BYTE = 8'h34;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_MAGIC    = 3'd1,
        ST_BAD_LENGTH   = 3'd2,
        ST_BAD_VERSION  = 3'd3,
        ST_BAD_DATA     = 3'd4,
        ST_BAD_TIME     = 3'd5,
        ST_SKIPPED_TIME = 3'd6
    } t_status;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status_code;
        logic [7:0]  packet_type;
        logic [7:0]  sequence_number;
        logic [31:0] time_seconds;
        logic [15:0] time_fraction;
        logic        time_known;
        logic        last_of_run;
    } t_result;

endpackage
`default_nettype wire

[rtl/sprd_byte_if.sv]
// Byte channel with valid and ready, used for serial input and configuration.
`default_nettype none
interface sprd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/sprd_res_if.sv]
// Result channel with valid and ready carrying one deframer result word.
`default_nettype none
interface sprd_res_if;
    import sprd_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/serial_packet_deframer_top.sv]
// Serial packet deframer: byte store in a circular RAM, header parse and status.
// Each byte: an accept step, then per parsed byte a loop check, a RAM read and an
// evaluate step, plus a header check or packet end step, up to 32 parses per byte,
// then a close of the run (final loop check, flush of the last word).
// A resync after an error scans held bytes from offset 1, a read and a compare per byte.
// Reset is synchronous, active low; it clears control state, the store is not cleared.
`default_nettype none
module serial_packet_deframer_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sprd_byte_if.sink    i_rx,
    sprd_byte_if.sink    i_cfg,
    sprd_res_if.source   o_res
);
    import sprd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOP, S_RD, S_EX, S_HDR, S_FIN, S_SRD, S_SEX, S_END
    } t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_base;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_scan;
    logic [K_W-1:0]    r_k;
    logic              r_hunt;
    logic [31:0]       r_tracked;
    logic [7:0]        r_sum;
    logic              r_matched;
    logic [7:0]        r_tcode;
    logic [7:0]        r_hdr [HDR_REGS];
    t_result           r_pend;
    logic              r_pend_v;
    t_result           r_out;
    logic              r_out_v;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;
    logic [CNT_W-1:0]  w_roff;
    logic [7:0]        w_b;
    logic [15:0]       w_len;
    logic [16:0]       w_end;
    logic              w_len_bad;
    logic [CNT_W-1:0]  w_pos_n;
    logic [31:0]       w_ts;
    logic [31:0]       w_trk_inc;
    logic              w_is_ts;
    logic              w_hdr_err;
    logic              w_fin_fail;
    logic              w_emit;
    t_result           w_res;
    logic              w_can_emit;
    logic              w_go;
    logic              w_full;

    // byte store
    sprd_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_rx.data),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_b)
    );

    assign w_full  = (r_count >= CNT_W'(STORE_BYTES));
    assign w_we    = (r_state == S_IDLE) && i_rx.valid && !w_full;
    assign w_waddr = r_base + r_count[ADDR_W-1:0];
    assign w_re    = (r_state == S_RD) || (r_state == S_SRD);
    assign w_roff  = (r_state == S_SRD) ? r_scan : r_pos;
    assign w_raddr = r_base + w_roff[ADDR_W-1:0];

    assign i_rx.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_v;
    assign o_res.data  = r_out;

    // header fields and checks
    assign w_len     = {r_hdr[4], r_hdr[3]};
    assign w_end     = 17'd11 + {1'b0, w_len};
    assign w_len_bad = (w_len != ~{r_hdr[6], r_hdr[5]}) || (w_len == 16'd0)
                       || (w_end > 17'(STORE_BYTES));
    assign w_pos_n   = r_pos + 1'b1;
    assign w_ts      = {r_hdr[15], r_hdr[14], r_hdr[13], r_hdr[12]};
    assign w_trk_inc = r_tracked + 32'd1;
    assign w_is_ts   = (r_hdr[11] == r_tcode);
    assign w_hdr_err = (r_hdr[0] != MAGIC_BYTE) || w_len_bad || (r_hdr[1] != VERSION_BYTE);
    assign w_fin_fail = (r_sum != r_hdr[2]) || (w_is_ts && (w_ts[7:0] != r_hdr[7]))
                        || (!w_is_ts && !r_matched);

    assign w_can_emit = !r_pend_v || !r_out_v;
    assign w_go       = !w_emit || w_can_emit;

    // build the result of the current step
    always_comb begin
        w_emit = 1'b0;
        w_res  = '0;
        unique case (r_state)
            S_EX: begin
                if (!(r_hunt && (w_b != MAGIC_BYTE)) && (r_pos >= CNT_W'(HEADER_BYTES))) begin
                    w_emit             = 1'b1;
                    w_res.item_kind    = KIND_PAYLOAD;
                    w_res.payload_byte = w_b;
                end
            end
            S_HDR: begin
                if (w_hdr_err) begin
                    w_emit          = 1'b1;
                    w_res.item_kind = KIND_STATUS;
                    priority if (r_hdr[0] != MAGIC_BYTE) begin
                        w_res.status_code = ST_BAD_MAGIC;
                    end else if (w_len_bad) begin
                        w_res.status_code     = ST_BAD_LENGTH;
                        w_res.packet_type     = r_hdr[11];
                        w_res.sequence_number = r_hdr[10];
                    end else begin
                        w_res.status_code     = ST_BAD_VERSION;
                        w_res.packet_type     = r_hdr[11];
                        w_res.sequence_number = r_hdr[10];
                    end
                end
            end
            S_FIN: begin
                w_emit                = 1'b1;
                w_res.item_kind       = KIND_STATUS;
                w_res.packet_type     = r_hdr[11];
                w_res.sequence_number = r_hdr[10];
                priority if (r_sum != r_hdr[2]) begin
                    w_res.status_code = ST_BAD_DATA;
                    w_res.time_known  = r_matched;
                end else if (w_is_ts && (w_ts[7:0] != r_hdr[7])) begin
                    w_res.status_code = ST_BAD_TIME;
                    w_res.time_known  = r_matched;
                end else if (!w_is_ts && !r_matched) begin
                    w_res.status_code = ST_SKIPPED_TIME;
                end else begin
                    w_res.status_code = ST_OK;
                    w_res.time_known  = 1'b1;
                end
                if (w_res.time_known) begin
                    w_res.time_seconds  = (w_is_ts && !w_fin_fail) ? w_ts : r_tracked;
                    w_res.time_fraction = {r_hdr[9], r_hdr[8]};
                end
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // state machine, store pointers, header registers and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_base    <= '0;
            r_count   <= '0;
            r_pos     <= '0;
            r_scan    <= '0;
            r_k       <= '0;
            r_hunt    <= 1'b0;
            r_tracked <= '0;
            r_sum     <= '0;
            r_matched <= 1'b0;
            r_tcode   <= '0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            // take the configuration word
            if (i_cfg.valid) begin
                r_tcode <= i_cfg.data;
            end
            // drop the delivered word
            if (r_out_v && o_res.ready) begin
                r_out_v <= 1'b0;
            end
            // push a new result behind the pending one
            if (w_emit && w_can_emit) begin
                if (r_pend_v) begin
                    r_out   <= {r_pend[$bits(t_result)-1:1], 1'b0};
                    r_out_v <= 1'b1;
                end
                r_pend   <= w_res;
                r_pend_v <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_rx.valid) begin
                        if (!w_full) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_k     <= '0;
                        r_state <= S_LOOP;
                    end
                end
                S_LOOP: begin
                    if ((r_k < K_W'(PARSE_PER_STEP)) && (r_pos < r_count)) begin
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_END;
                    end
                end
                S_RD: begin
                    r_state <= S_EX;
                end
                S_EX: begin
                    if (w_go) begin
                        r_k <= r_k + 1'b1;
                        if (r_hunt && (w_b != MAGIC_BYTE)) begin
                            r_base  <= r_base + 1'b1;
                            r_count <= r_count - 1'b1;
                            r_pos   <= '0;
                            r_state <= S_LOOP;
                        end else begin
                            r_hunt <= 1'b0;
                            r_pos  <= w_pos_n;
                            if (r_pos < CNT_W'(HDR_REGS)) begin
                                r_hdr[r_pos[3:0]] <= w_b;
                            end
                            if (r_pos == CNT_W'(HEADER_BYTES - 1)) begin
                                r_state <= S_HDR;
                            end else if (r_pos >= CNT_W'(HEADER_BYTES)) begin
                                r_sum <= r_sum + w_b;
                                if (17'(w_pos_n) == w_end) begin
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_LOOP;
                                end
                            end else begin
                                r_state <= S_LOOP;
                            end
                        end
                    end
                end
                S_HDR: begin
                    if (w_go) begin
                        if (w_hdr_err) begin
                            r_scan  <= CNT_W'(1);
                            r_state <= S_SRD;
                        end else begin
                            // track seconds from the low byte
                            if (r_tracked[7:0] == r_hdr[7]) begin
                                r_matched <= 1'b1;
                            end else if (w_trk_inc[7:0] == r_hdr[7]) begin
                                r_tracked <= w_trk_inc;
                                r_matched <= 1'b1;
                            end else begin
                                r_matched <= 1'b0;
                            end
                            r_sum     <= r_hdr[11];
                            r_hdr[12] <= '0;
                            r_hdr[13] <= '0;
                            r_hdr[14] <= '0;
                            r_hdr[15] <= '0;
                            r_state   <= (w_len == 16'd1) ? S_FIN : S_LOOP;
                        end
                    end
                end
                S_FIN: begin
                    if (w_go) begin
                        if (w_fin_fail) begin
                            r_scan  <= CNT_W'(1);
                            r_state <= S_SRD;
                        end else begin
                            if (w_is_ts) begin
                                r_tracked <= w_ts;
                            end
                            r_base  <= r_base + w_end[ADDR_W-1:0];
                            r_count <= r_count - w_end[CNT_W-1:0];
                            r_pos   <= '0;
                            r_state <= S_LOOP;
                        end
                    end
                end
                S_SRD: begin
                    if (r_scan < r_count) begin
                        r_state <= S_SEX;
                    end else begin
                        r_count <= '0;
                        r_pos   <= '0;
                        r_hunt  <= 1'b1;
                        r_state <= S_LOOP;
                    end
                end
                S_SEX: begin
                    if (w_b == MAGIC_BYTE) begin
                        r_base  <= r_base + r_scan[ADDR_W-1:0];
                        r_count <= r_count - r_scan;
                        r_pos   <= '0;
                        r_state <= S_LOOP;
                    end else begin
                        r_scan  <= r_scan + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_END: begin
                    // flush the last result of the run
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (!r_out_v) begin
                        r_out    <= {r_pend[$bits(t_result)-1:1], 1'b1};
                        r_out_v  <= 1'b1;
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STORE_BYTES))
        else $error("store count beyond capacity");
    a_pos_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_count)
        else $error("parse position beyond held bytes");
    a_idle_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("pending result left when idle");
    a_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_k < K_W'(PARSE_PER_STEP)))
        else $error("parse budget exceeded");
endmodule
`default_nettype wire

[rtl/sprd_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module sprd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire
